### rtl/core/lph_pkg.sv
// Shared types, constants and the FNV-1a step for the linear probe hash table.
package lph_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 64;
  localparam int SLOT_W  = 6;
  localparam int LIMIT_W = 7;
  localparam int HASH_W  = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_OCC  = 2'd1;
  localparam logic [1:0] MARK_DEL  = 2'd2;

  localparam logic [HASH_W-1:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
  // 64-bit FNV prime is 2^40 + 0x1b3: a shift plus a narrow multiply
  localparam int             FNV_SHIFT    = 40;
  localparam logic [8:0]     FNV_PRIME_LO = 9'h1B3;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return (x << FNV_SHIFT) + HASH_W'(x * FNV_PRIME_LO);
  endfunction

endpackage

### rtl/core/lph_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/lph_hash.sv
// Home slot: two FNV-1a byte steps, then a mask (power-of-two capacity) or folded remainder.
module lph_hash import lph_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [KEY_W-1:0]            key,
  output logic                        done,
  output logic [$clog2(CAPACITY)-1:0] home
);

  localparam int IW      = $clog2(CAPACITY);
  localparam int RW      = IW + 1;
  localparam int CHUNK_W = 16;
  localparam int PW      = CHUNK_W + IW;
  localparam int SW      = PW + 2;
  localparam int QW      = SW + 32;
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  function automatic int pow2_mod(input int e);
    int p;
    p = 1;
    for (int i = 0; i < e; i++) begin
      p = (p * 2) % CAPACITY;
    end
    return p;
  endfunction

  // place value of each upper 16-bit chunk of the hash, mod CAPACITY
  localparam logic [IW-1:0] FOLD1 = IW'(pow2_mod(16));
  localparam logic [IW-1:0] FOLD2 = IW'(pow2_mod(32));
  localparam logic [IW-1:0] FOLD3 = IW'(pow2_mod(48));
  // floor(2^32 / CAPACITY): with the folded sum below 2^32 the quotient is at most one short
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));

  typedef enum logic [5:0] {
    H_IDLE = 6'b000001,
    H_FNV  = 6'b000010,
    H_FOLD = 6'b000100,
    H_QUO  = 6'b001000,
    H_REM  = 6'b010000,
    H_FIX  = 6'b100000
  } hstate_t;

  hstate_t             hstate;
  logic [HASH_W-1:0]   h;
  logic [KEY_W-1:0]    kbuf;
  logic                bsel;
  logic [1:0]          mcnt;
  logic [SW-1:0]       sacc;
  logic [SW-1:0]       quo;
  logic [RW-1:0]       rem;

  logic [HASH_W-1:0]   h_fnv;
  logic [IW-1:0]       fold_k;
  logic [PW-1:0]       fold_prod;
  logic [QW-1:0]       quo_prod;
  logic [RW-1:0]       rem_fix;

  always_comb begin
    h_fnv = fnv_step(h, bsel ? kbuf[15:8] : kbuf[7:0]);
    case (mcnt)
      2'd0:    fold_k = IW'(1);
      2'd1:    fold_k = FOLD1;
      2'd2:    fold_k = FOLD2;
      default: fold_k = FOLD3;
    endcase
    fold_prod = PW'(h[CHUNK_W-1:0]) * PW'(fold_k);
    quo_prod  = QW'(sacc) * QW'(RECIP);
    rem_fix   = (rem >= RW'(CAPACITY)) ? rem - RW'(CAPACITY) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hstate <= H_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (hstate)
        H_IDLE: begin
          if (start) begin
            h      <= FNV_OFFSET;
            kbuf   <= key;
            bsel   <= 1'b0;
            hstate <= H_FNV;
          end
        end
        H_FNV: begin
          h    <= h_fnv;
          bsel <= 1'b1;
          if (bsel) begin
            if (IS_POW2) begin
              home   <= h_fnv[IW-1:0];
              done   <= 1'b1;
              hstate <= H_IDLE;
            end else begin
              sacc   <= '0;
              mcnt   <= '0;
              hstate <= H_FOLD;
            end
          end
        end
        H_FOLD: begin
          // one 16-bit chunk per cycle, low chunk first
          sacc <= sacc + SW'(fold_prod);
          h    <= h >> CHUNK_W;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 2'd3) begin
            hstate <= H_QUO;
          end
        end
        H_QUO: begin
          quo    <= quo_prod[QW-1:32];
          hstate <= H_REM;
        end
        H_REM: begin
          // true remainder here is below 2 * CAPACITY, so the low bits suffice
          rem    <= sacc[RW-1:0] - RW'(quo[RW-1:0] * RW'(CAPACITY));
          hstate <= H_FIX;
        end
        H_FIX: begin
          home   <= rem_fix[IW-1:0];
          done   <= 1'b1;
          hstate <= H_IDLE;
        end
        default: hstate <= H_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/linear_probe_hash_table.sv
// Linear probe hash table: top level with request sequencer and slot store.
// Open-addressing map from a 16-bit key to a 64-bit value in CAPACITY slots, one request
// at a time. A set, get or remove is accepted, hashed over both key bytes with FNV-1a
// (plus a folded remainder when CAPACITY is not a power of two), fetches the home slot,
// then probes one slot per cycle through the single read port of the slot RAM, and
// then loads the result register. A clear sweeps the mark of every slot, one per cycle.
// After reset the same clearing pass runs before the first request is taken;
// load_limit writes are accepted throughout. The result register lets the next request
// enter while a result beat still waits to be taken.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [KEY_W-1:0]   key,
  input  logic [VAL_W-1:0]   value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [VAL_W-1:0]   value_out,
  output logic [SLOT_W-1:0]  slot,
  output logic               status
);

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_PROBE = 5'b00100,
    S_SWEEP = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [IW-1:0]       idx, idx_next;
  logic [IW-1:0]       cnt, cnt_next;
  logic [IW-1:0]       ins_idx, ins_idx_next;
  logic                ins_ok, ins_ok_next;
  logic [LIMIT_W-1:0]  insert_count, insert_count_next;
  logic [LIMIT_W-1:0]  load_limit;
  logic                sweep_reply, sweep_reply_next;

  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    value_r;

  logic                res_found, res_found_next;
  logic [VAL_W-1:0]    res_value, res_value_next;
  logic [SLOT_W-1:0]   res_slot, res_slot_next;
  logic                res_status, res_status_next;

  logic                accept;
  logic                hash_start;
  logic                hash_done;
  logic [IW-1:0]       home;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_entry;
  logic [ENTRY_W-1:0]  rd_data;
  entry_t              rd_entry;

  logic                is_free, is_occ, key_eq, hit, stop;
  logic                ins_now_ok;
  logic [IW-1:0]       ins_now;
  logic [IW-1:0]       idx_inc;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign hash_start = accept && (cmd != CMD_CLEAR);
  assign rd_entry   = rd_data;

  lph_hash #(.CAPACITY(CAPACITY)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key),
    .done  (hash_done),
    .home  (home)
  );

  // read address is idx_next, the value idx takes next, so rd_entry always belongs to idx
  lph_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  always_comb begin
    is_free    = (rd_entry.mark == MARK_FREE);
    is_occ     = (rd_entry.mark == MARK_OCC);
    key_eq     = (rd_entry.key == key_r);
    hit        = !is_free && key_eq && is_occ;
    stop       = is_free || key_eq || (cnt == LAST_IDX);
    ins_now_ok = ins_ok || !is_occ;
    ins_now    = ins_ok ? ins_idx : idx;
    idx_inc    = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    cnt_next          = cnt;
    ins_idx_next      = ins_idx;
    ins_ok_next       = ins_ok;
    insert_count_next = insert_count;
    sweep_reply_next  = sweep_reply;
    res_found_next    = res_found;
    res_value_next    = res_value;
    res_slot_next     = res_slot;
    res_status_next   = res_status;
    wr_en             = 1'b0;
    wr_addr           = idx;
    wr_entry          = '{mark: MARK_OCC, key: key_r, value: value_r};

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_found_next  = 1'b0;
          res_value_next  = '0;
          res_slot_next   = '0;
          res_status_next = 1'b0;
          if (cmd == CMD_CLEAR) begin
            idx_next          = '0;
            insert_count_next = '0;
            sweep_reply_next  = 1'b1;
            state_next        = S_SWEEP;
          end else begin
            cnt_next    = '0;
            ins_ok_next = 1'b0;
            state_next  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_next   = home;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop) begin
          state_next = S_RESP;
          case (cmd_r)
            CMD_SET: begin
              if (hit) begin
                wr_en          = 1'b1;
                res_found_next = 1'b1;
                res_slot_next  = SLOT_W'(idx);
              end else if (insert_count >= load_limit) begin
                res_status_next = 1'b1;
              end else if (ins_now_ok) begin
                wr_en             = 1'b1;
                wr_addr           = ins_now;
                insert_count_next = LIMIT_W'(insert_count + 1'b1);
                res_slot_next     = SLOT_W'(ins_now);
              end else begin
                res_status_next = 1'b1;
              end
            end
            CMD_GET: begin
              if (hit) begin
                res_found_next = 1'b1;
                res_value_next = rd_entry.value;
                res_slot_next  = SLOT_W'(idx);
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                wr_en          = 1'b1;
                wr_entry       = '{mark: MARK_DEL, key: rd_entry.key, value: rd_entry.value};
                res_found_next = 1'b1;
                res_slot_next  = SLOT_W'(idx);
              end
            end
            default: ;
          endcase
        end else begin
          // remember the first slot a new key could take
          ins_ok_next  = ins_now_ok;
          ins_idx_next = ins_now;
          idx_next     = idx_inc;
          cnt_next     = cnt + 1'b1;
        end
      end
      S_SWEEP: begin
        wr_en    = 1'b1;
        wr_entry = '{mark: MARK_FREE, key: '0, value: '0};
        idx_next = idx_inc;
        if (idx == LAST_IDX) begin
          sweep_reply_next = 1'b0;
          state_next       = sweep_reply ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      idx          <= '0;
      cnt          <= '0;
      ins_ok       <= 1'b0;
      insert_count <= '0;
      load_limit   <= LIMIT_RESET;
      sweep_reply  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      cnt          <= cnt_next;
      ins_ok       <= ins_ok_next;
      insert_count <= insert_count_next;
      sweep_reply  <= sweep_reply_next;
      if (cfg_wr_en) begin
        load_limit <= cfg_wr_data;
      end
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_idx    <= ins_idx_next;
    res_found  <= res_found_next;
    res_value  <= res_value_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    if (accept) begin
      cmd_r   <= cmd;
      key_r   <= key;
      value_r <= value;
    end
    if (state == S_RESP && (!out_valid || out_ready)) begin
      found     <= res_found;
      value_out <= res_value;
      slot      <= res_slot;
      status    <= res_status;
    end
  end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the linear probe hash table, with a mirror of the slot store.
import lph_pkg::*;

class map_mirror;
  typedef struct {
    logic             found;
    logic [VAL_W-1:0] value_out;
    logic [SLOT_W-1:0] slot;
    logic             status;
    int unsigned      seq;
  } reply_t;

  logic [KEY_W-1:0]   key_m   [CAPACITY_DEF];
  logic [VAL_W-1:0]   val_m   [CAPACITY_DEF];
  logic [1:0]         mark_m  [CAPACITY_DEF];
  logic [LIMIT_W-1:0] insert_cnt;
  logic [LIMIT_W-1:0] load_limit;

  reply_t      replies_due[$];
  int unsigned seq_no;
  int unsigned errors;
  int unsigned n_cmd[4];
  int unsigned n_hit;
  int unsigned n_refused;
  int unsigned n_wrap_refused;

  function new();
    foreach (mark_m[i]) begin
      mark_m[i] = MARK_FREE;
      key_m[i]  = '0;
      val_m[i]  = '0;
    end
    insert_cnt = '0;
    load_limit = LIMIT_RESET;
  endfunction

  // FNV-1a over low byte then high byte, reduced to a slot index
  function logic [SLOT_W-1:0] home_slot(logic [KEY_W-1:0] k);
    logic [63:0] h;
    h = 64'hCBF2_9CE4_8422_2325;
    h = (h ^ {56'd0, k[7:0]}) * 64'd1099511628211;
    h = (h ^ {56'd0, k[15:8]}) * 64'd1099511628211;
    return SLOT_W'(h % 64'(CAPACITY_DEF));
  endfunction

  function bit probe_hit(input logic [KEY_W-1:0] k, output int where);
    int idx;
    idx = int'(home_slot(k));
    where = 0;
    for (int n = 0; n < CAPACITY_DEF; n++) begin
      if (mark_m[idx] == MARK_FREE) return 1'b0;
      if (key_m[idx] == k) begin
        if (mark_m[idx] == MARK_OCC) begin
          where = idx;
          return 1'b1;
        end
        return 1'b0;  // tombstone with the same key ends the search
      end
      idx = (idx + 1) % CAPACITY_DEF;
    end
    return 1'b0;
  endfunction

  function void note_request(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    reply_t r;
    int where;
    int idx;
    int n;
    r.found = 1'b0;
    r.value_out = '0;
    r.slot = '0;
    r.status = 1'b0;
    r.seq = seq_no;
    n_cmd[c]++;
    case (c)
      CMD_SET: begin
        if (probe_hit(k, where)) begin
          val_m[where] = v;
          r.found = 1'b1;
          r.slot = SLOT_W'(where);
        end else if (insert_cnt >= load_limit) begin
          r.status = 1'b1;
        end else begin
          idx = int'(home_slot(k));
          n = 0;
          while (n < CAPACITY_DEF && mark_m[idx] == MARK_OCC) begin
            idx = (idx + 1) % CAPACITY_DEF;
            n++;
          end
          if (n < CAPACITY_DEF) begin
            key_m[idx] = k;
            val_m[idx] = v;
            mark_m[idx] = MARK_OCC;
            insert_cnt = insert_cnt + 1'b1;
            r.slot = SLOT_W'(idx);
          end else begin
            r.status = 1'b1;
            n_wrap_refused++;
          end
        end
      end
      CMD_GET: begin
        if (probe_hit(k, where)) begin
          r.found = 1'b1;
          r.value_out = val_m[where];
          r.slot = SLOT_W'(where);
        end
      end
      CMD_REMOVE: begin
        if (probe_hit(k, where)) begin
          mark_m[where] = MARK_DEL;
          r.found = 1'b1;
          r.slot = SLOT_W'(where);
        end
      end
      default: begin
        foreach (mark_m[i]) mark_m[i] = MARK_FREE;
        insert_cnt = '0;
      end
    endcase
    if (r.found) n_hit++;
    if (r.status) n_refused++;
    replies_due.push_back(r);
    seq_no++;
  endfunction

  task report_mismatch(string what, int unsigned seq, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("tb: mismatch on %s, request %0d: got %0h, want %0h", what, seq, got, want);
  endtask

  task check_reply(logic f, logic [VAL_W-1:0] vo, logic [SLOT_W-1:0] s, logic st);
    reply_t w;
    if (replies_due.size() == 0) begin
      report_mismatch("beat with nothing outstanding", seq_no, 64'(s), 64'd0);
      return;
    end
    w = replies_due.pop_front();
    if (f !== w.found) report_mismatch("found", w.seq, 64'(f), 64'(w.found));
    if (vo !== w.value_out) report_mismatch("value_out", w.seq, vo, w.value_out);
    if (s !== w.slot) report_mismatch("slot", w.seq, 64'(s), 64'(w.slot));
    if (st !== w.status) report_mismatch("status", w.seq, 64'(st), 64'(w.status));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd = CMD_GET;
  logic [KEY_W-1:0]   key = '0;
  logic [VAL_W-1:0]   value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [VAL_W-1:0]   value_out;
  logic [SLOT_W-1:0]  slot;
  logic               status;

  map_mirror   mirror = new();
  bit          idle_tx = 1'b1;
  bit          idle_rx = 1'b1;
  int unsigned cycles = 0;

  linear_probe_hash_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .value_out  (value_out),
    .slot       (slot),
    .status     (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_req(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = idle_tx ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(c, k, v);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.load_limit = lim;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (mirror.replies_due.size() != 0);
  endtask

  // result side: random stalls, in stretches
  initial begin
    int stall;
    int unsigned got;
    got = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (got % 100 == 0) idle_rx = ($urandom_range(0, 3) != 0);
      stall = idle_rx ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      mirror.check_reply(found, value_out, slot, status);
      got++;
    end
  end

  initial begin
    logic [KEY_W-1:0]   pool [20];
    logic [KEY_W-1:0]   kc;
    logic [KEY_W-1:0]   k;
    logic [CMD_W-1:0]   c;
    logic [VAL_W-1:0]   v;
    logic [LIMIT_W-1:0] lim;
    logic [SLOT_W-1:0]  target;
    int r;
    int base;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: tiny limit so refusal comes quickly
    write_limit(7'd3);
    kc = 16'd1;
    while (kc == 16'hFFFF || mirror.home_slot(kc) != mirror.home_slot(16'h0000)) kc++;
    send_req(CMD_SET, 16'h0000, '1);
    send_req(CMD_SET, 16'hFFFF, '0);
    send_req(CMD_GET, 16'h0000, '0);
    send_req(CMD_SET, 16'h0000, 64'h5555_5555_AAAA_AAAA);  // overwrite
    send_req(CMD_GET, 16'hFFFF, '1);
    send_req(CMD_GET, 16'h8001, '0);
    send_req(CMD_SET, kc, 64'h0123_4567_89AB_CDEF);       // same home as key 0
    send_req(CMD_SET, 16'h7F7F, 64'h1);                    // limit reached
    send_req(CMD_REMOVE, 16'h0000, '0);
    send_req(CMD_GET, 16'h0000, '0);                       // stops on its tombstone
    send_req(CMD_GET, kc, '0);                             // probes past the tombstone
    send_req(CMD_REMOVE, 16'h0000, '0);
    send_req(CMD_SET, 16'h0000, 64'h2);                    // remove left count as it was
    send_req(CMD_CLEAR, 16'hFFFF, '1);
    send_req(CMD_GET, 16'hFFFF, '0);
    drain();
    write_limit(7'd0);
    send_req(CMD_SET, 16'h1234, 64'h3);
    send_req(CMD_GET, 16'h1234, '0);
    send_req(CMD_CLEAR, 16'h0000, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: lim = 7'd64;
        1: lim = 7'd1;
        2: lim = 7'd127;
        3: lim = 7'd32;
        default: lim = LIMIT_W'($urandom_range(2, 63));
      endcase
      write_limit(lim);

      if (p == 2) begin
        // limit above capacity: fill every slot, then force a full wrap
        send_req(CMD_CLEAR, '0, '0);
        base = $urandom_range(0, 1700);
        for (int i = 0; i < 70; i++) begin
          send_req(CMD_SET, KEY_W'(base + i * 911), {$urandom(), $urandom()});
        end
        for (int i = 0; i < 40; i++) begin
          r = $urandom_range(0, 2);
          c = (r == 0) ? CMD_GET : (r == 1) ? CMD_REMOVE : CMD_SET;
          send_req(c, KEY_W'(base + $urandom_range(0, 69) * 911), {$urandom(), $urandom()});
        end
      end else begin
        // pool: a chain of keys sharing one home, the key extremes, and random keys
        target = (p == 4) ? SLOT_W'(62) : SLOT_W'($urandom_range(0, 63));
        for (int i = 0; i < 8; i++) begin
          do k = KEY_W'($urandom()); while (mirror.home_slot(k) != target);
          pool[i] = k;
        end
        pool[8] = '0;
        pool[9] = '1;
        for (int i = 10; i < 20; i++) pool[i] = KEY_W'($urandom());

        for (int i = 0; i < 255; i++) begin
          if (i % 100 == 0) idle_tx = ($urandom_range(0, 3) != 0);
          if (i == 120) drain();
          r = $urandom_range(0, 99);
          c = (r < 44) ? CMD_SET : (r < 74) ? CMD_GET : (r < 97) ? CMD_REMOVE : CMD_CLEAR;
          k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom()) : pool[$urandom_range(0, 19)];
          case ($urandom_range(0, 15))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom(), $urandom()};
          endcase
          send_req(c, k, v);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d requests (%0d set, %0d get, %0d remove, %0d clear), %0d hits",
             mirror.seq_no, mirror.n_cmd[CMD_SET], mirror.n_cmd[CMD_GET],
             mirror.n_cmd[CMD_REMOVE], mirror.n_cmd[CMD_CLEAR], mirror.n_hit);
    $display("tb: %0d sets refused (%0d on a full table), limits 0 to 127, %0d mismatches",
             mirror.n_refused, mirror.n_wrap_refused, mirror.errors);
    if (mirror.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
